>>> design/matrix4_vector_transform_defines.svh
// Assertion macros used by the checker file.
`ifndef MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH

// Same-cycle implication, abandoned while rst is high.
`define M4VT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, abandoned while rst is high.
`define M4VT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/m4vt_pkg.sv
package m4vt_pkg;

   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = $clog2(NUM_REGS);
   localparam int CSR_DATA_W  = 64;
   localparam int Q_W         = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = 2 * Q_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int SHIFT_W     = SUM_W - FRAC_BITS;

   localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_BITS);
   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   // Identity matrix, column major, two rows per register.
   localparam logic [NUM_REGS-1:0][CSR_DATA_W-1:0] MAT_RESET = {
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
   };

   typedef logic signed [Q_W-1:0] q_type;
   typedef q_type [3:0] vec_type;

   typedef struct packed {
      logic  mode;
      q_type in_x;
      q_type in_y;
      q_type in_z;
      q_type in_w;
   } req_type;

   typedef struct packed {
      q_type out_x;
      q_type out_y;
      q_type out_z;
      q_type out_w;
   } rsp_type;

   // Load strobes for the three compute stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } adv_type;

endpackage

>>> design/m4vt_row.sv
module m4vt_row (
   input  logic              clock,
   input  m4vt_pkg::adv_type adv,
   input  m4vt_pkg::vec_type coef,
   input  m4vt_pkg::vec_type vec,
   output m4vt_pkg::q_type   result
);
   import m4vt_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff [4];
   logic signed [PAIR_W-1:0]  pair_ff [2];
   logic signed [SUM_W-1:0]   sum;
   logic signed [SHIFT_W-1:0] shifted;
   q_type                     result_in;
   q_type                     result_ff;

   // Stage 1: one multiplier per column.
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         for (int c = 0; c < 4; c++) begin
            prod_ff[c] <= PROD_W'($signed(coef[c])) * PROD_W'($signed(vec[c]));
         end
      end
   end

   // Stage 2: pairwise sums, exact.
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         pair_ff[0] <= PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
         pair_ff[1] <= PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      end
   end

   // Stage 3: final sum, floor shift, saturate.
   always_comb begin
      sum     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
      shifted = SHIFT_W'(sum >>> FRAC_BITS);
      if (shifted > SHIFT_W'(Q_MAX)) begin
         result_in = Q_MAX;
      end else if (shifted < SHIFT_W'(Q_MIN)) begin
         result_in = Q_MIN;
      end else begin
         result_in = shifted[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> design/matrix4_vector_transform.sv
// Channel  Ports                               Direction  Moves
// req      req_valid/req_stall/req_data        in         one vector and mode
// rsp      rsp_valid/rsp_stall/rsp_data        out        one transformed vector
// csr      csr_wr_en/csr_index/csr_wr_data     in         one matrix register
//
// Throughput is one item per cycle while rsp does not stall; the accepting
// edge loads the input register, then the multiplier stage, the pair-add
// stage and the final add with saturation follow, and rsp_valid rises with
// the last of these. Sixteen 32x32 multipliers work in parallel, four per row.
// Synchronous reset clears all valid bits and loads the identity matrix.
// A stage holds only while it and every stage after it are full and rsp stalls.
module matrix4_vector_transform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  m4vt_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output m4vt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [m4vt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [m4vt_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import m4vt_pkg::*;

   logic [NUM_REGS-1:0][CSR_DATA_W-1:0] mat_ff;

   logic    valid0_ff, valid1_ff, valid2_ff, valid3_ff;
   logic    point0_ff, point1_ff, point2_ff, point3_ff;
   logic    rdy0, rdy1, rdy2, rdy3;
   vec_type vec0_ff;
   vec_type vec_in;
   adv_type adv;
   q_type   row_result [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_wr_en) begin
         mat_ff[csr_index] <= csr_wr_data;
      end
   end

   // A stage takes new data when it is empty or its successor moves.
   assign rdy3      = !valid3_ff || !rsp_stall;
   assign rdy2      = !valid2_ff || rdy3;
   assign rdy1      = !valid1_ff || rdy2;
   assign rdy0      = !valid0_ff || rdy1;
   assign req_stall = !rdy0;
   assign adv       = '{s1: rdy1, s2: rdy2, s3: rdy3};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (rdy0) valid0_ff <= req_valid;
         if (rdy1) valid1_ff <= valid0_ff;
         if (rdy2) valid2_ff <= valid1_ff;
         if (rdy3) valid3_ff <= valid2_ff;
      end
   end

   // Point mode: force w to one so the translation column is added as is.
   always_comb begin
      vec_in[0] = req_data.in_x;
      vec_in[1] = req_data.in_y;
      vec_in[2] = req_data.in_z;
      vec_in[3] = req_data.mode ? ONE_Q : req_data.in_w;
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_valid) begin
         vec0_ff   <= vec_in;
         point0_ff <= req_data.mode;
      end
      if (rdy1) point1_ff <= point0_ff;
      if (rdy2) point2_ff <= point1_ff;
      if (rdy3) point3_ff <= point2_ff;
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      vec_type coef;
      for (genvar c = 0; c < 4; c++) begin : g_col
         assign coef[c] = mat_ff[c*2 + r/2][(r%2)*Q_W +: Q_W];
      end
      m4vt_row u_row (
         .clock  (clock),
         .adv    (adv),
         .coef   (coef),
         .vec    (vec0_ff),
         .result (row_result[r])
      );
   end

   assign rsp_valid      = valid3_ff;
   assign rsp_data.out_x = row_result[0];
   assign rsp_data.out_y = row_result[1];
   assign rsp_data.out_z = row_result[2];
   assign rsp_data.out_w = point3_ff ? '0 : row_result[3];

endmodule

>>> design/m4vt_checker.sv
`include "matrix4_vector_transform_defines.svh"

module m4vt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input m4vt_pkg::rsp_type rsp_data
);
   import m4vt_pkg::*;

   `M4VT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")

   `M4VT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled rsp item changed")

   `M4VT_ASSERT_NOW(a_empty_no_stall, clock, reset, !rsp_valid, !req_stall, "req stalled while output is empty")

   `M4VT_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid, "item not delivered after four free cycles")

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
